>>> rtl/rle4_pkg.sv
// ----------------------------------------------------------------------------
// rle4_pkg
// shared types, constants and helpers of the 4bpp run-length pixel decoder
// ----------------------------------------------------------------------------
package rle4_pkg;

	localparam int PIXEL_COUNT_BITS_DEF = 20;
	localparam int DIM_W                = 10;
	localparam int LIMIT_W              = 2 * DIM_W;
	localparam int CAP_W                = 22;
	localparam int NIB_W                = 4;
	localparam int CFG_DATA_W           = 22;
	localparam int IDX_W                = 19;
	localparam int RUN_W                = 7;
	localparam int NIB_SLOTS            = 6;
	localparam int NIB_REG_W            = NIB_SLOTS * NIB_W;
	localparam logic [NIB_W-1:0] WHITE_RESET = 4'hF;

	typedef enum logic [1:0] {
		REG_AREA_WIDTH  = 2'd0,
		REG_AREA_HEIGHT = 2'd1,
		REG_OUT_CAP     = 2'd2,
		REG_WHITE_COLOR = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RUN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic decode;
		logic step;
		logic flush;
	} dp_cmd_t;

	typedef struct packed {
		logic run_start;
		logic run_end;
		logic last;
		logic out_free;
	} dp_stat_t;

	// continuation bytes that follow a copy header
	function automatic logic [1:0] copy_bytes(input logic [1:0] len_code);
		logic [1:0] res;
		unique case (len_code)
			2'd0:    res = 2'd1;
			2'd1:    res = 2'd2;
			2'd2:    res = 2'd2;
			default: res = 2'd3;
		endcase
		return res;
	endfunction

endpackage

>>> rtl/rle4_code_if.sv
// ----------------------------------------------------------------------------
// rle4_code_if
// compressed byte channel: one code byte and its end-of-frame mark per beat
// ----------------------------------------------------------------------------
interface rle4_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last_byte;

	modport source(output valid, output in_byte, output last_byte, input ready);
	modport sink(input valid, input in_byte, input last_byte, output ready);
endinterface

>>> rtl/rle4_pix_if.sv
// ----------------------------------------------------------------------------
// rle4_pix_if
// packed pixel channel: one output byte with its buffer position per beat
// ----------------------------------------------------------------------------
interface rle4_pix_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [18:0] byte_index;
	logic        run_last;
	logic        frame_done;

	modport source(output valid, output out_byte, output byte_index, output run_last,
		output frame_done, input ready);
	modport sink(input valid, input out_byte, input byte_index, input run_last,
		input frame_done, output ready);
endinterface

>>> rtl/rle4_ctrl.sv
// ----------------------------------------------------------------------------
// rle4_ctrl
// sequencer: takes a code byte, decodes it, steps the run, flushes the frame
// ----------------------------------------------------------------------------
module rle4_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rle4_pkg::dp_stat_t stat,
	output rle4_pkg::dp_cmd_t  cmd
);
	import rle4_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (stat.run_start) begin
					state_nxt = ST_RUN;
				end else if (stat.last) begin
					state_nxt = ST_FLUSH;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_RUN: begin
				if (stat.out_free && stat.run_end) begin
					state_nxt = stat.last ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.decode = 1'b0;
		cmd.step   = 1'b0;
		cmd.flush  = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready   = 1'b1;
			ST_DECODE: cmd.decode = 1'b1;
			ST_RUN:    cmd.step   = stat.out_free;
			ST_FLUSH:  cmd.flush  = stat.out_free;
			default:   in_ready   = 1'b0;
		endcase
	end

endmodule

>>> rtl/rle4_dp.sv
// ----------------------------------------------------------------------------
// rle4_dp
// datapath: config registers, frame limit, copy state, pixel run stepper
// and the output beat register
// ----------------------------------------------------------------------------
module rle4_dp #(
	parameter int PIXEL_COUNT_BITS = rle4_pkg::PIXEL_COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rle4_pkg::dp_cmd_t              cmd,
	output rle4_pkg::dp_stat_t             stat,
	input  logic                           load,
	input  logic [7:0]                     in_byte,
	input  logic                           last_byte,
	input  logic                           cfg_we,
	input  rle4_pkg::cfg_reg_t             cfg_index,
	input  logic [rle4_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     out_byte,
	output logic [rle4_pkg::IDX_W-1:0]     byte_index,
	output logic                           run_last,
	output logic                           frame_done
);
	import rle4_pkg::*;

	localparam int CW = ((PIXEL_COUNT_BITS > LIMIT_W) ? PIXEL_COUNT_BITS : LIMIT_W) + 1;

	// configuration
	logic [DIM_W-1:0]   area_w_q;
	logic [DIM_W-1:0]   area_h_q;
	logic [CAP_W-1:0]   cap_q;
	logic [NIB_W-1:0]   white_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               cap_fail_q;

	// item and frame state
	logic [7:0]                  byte_q;
	logic                        last_q;
	logic [PIXEL_COUNT_BITS-1:0] pc_q;
	logic [NIB_W-1:0]            partial_q;
	logic                        cp_pend_q;
	logic [1:0]                  cp_nn_q;
	logic [NIB_W-1:0]            cp_hl_q;
	logic [15:0]                 cp_data_q;
	logic [1:0]                  cp_left_q;
	logic [RUN_W-1:0]            run_q;
	logic [NIB_REG_W-1:0]        nib_q;
	logic [NIB_W-1:0]            fill_q;

	logic                        out_valid_q;
	logic [7:0]                  out_byte_q;
	logic [IDX_W-1:0]            byte_index_q;
	logic                        run_last_q;
	logic                        frame_done_q;

	// decode
	logic                        is_white;
	logic                        is_hdr;
	logic [1:0]                  cp_left_dec;
	logic                        cp_finish;
	logic [RUN_W-1:0]            cnt_sel;
	logic [CW-1:0]               pc_x;
	logic [CW-1:0]               limit_x;
	logic [CW-1:0]               sum_x;
	logic [CW-1:0]               diff_x;
	logic                        fits;
	logic                        below;
	logic [RUN_W-1:0]            run_load;
	logic [NIB_REG_W-1:0]        nib_load;
	logic [NIB_W-1:0]            fill_load;

	// step
	logic [NIB_W-1:0]            n0;
	logic [NIB_W-1:0]            n1;
	logic                        odd;
	logic                        pair;
	logic                        step_emit;
	logic [RUN_W-1:0]            run_next;
	logic [PIXEL_COUNT_BITS-1:0] pc_step;
	logic [7:0]                  step_byte;
	logic                        step_final;
	logic                        emit_any;
	logic                        emit_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_w_q   <= '0;
			area_h_q   <= '0;
			cap_q      <= '0;
			white_q    <= WHITE_RESET;
			limit_q    <= '0;
			cap_fail_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_AREA_WIDTH:  area_w_q <= cfg_data[DIM_W-1:0];
					REG_AREA_HEIGHT: area_h_q <= cfg_data[DIM_W-1:0];
					REG_OUT_CAP:     cap_q    <= cfg_data[CAP_W-1:0];
					REG_WHITE_COLOR: white_q  <= cfg_data[NIB_W-1:0];
					default:         white_q  <= white_q;
				endcase
			end
			limit_q    <= area_w_q * area_h_q;
			cap_fail_q <= CAP_W'({limit_q, 1'b0}) > cap_q;
		end
	end

	assign is_white    = byte_q[7] & byte_q[6];
	assign is_hdr      = byte_q[7] & ~byte_q[6];
	assign cp_left_dec = cp_left_q - 2'd1;
	assign cp_finish   = cp_pend_q && (cp_left_dec == 2'd0);

	always_comb begin
		if (cp_pend_q) begin
			cnt_sel = RUN_W'({1'b0, cp_nn_q} + 3'd3);
		end else if (is_white) begin
			cnt_sel = {1'b0, byte_q[5:0]} + 7'd1;
		end else begin
			cnt_sel = {3'b000, {1'b0, byte_q[6:4]} + 4'd1};
		end
	end

	assign pc_x    = CW'(pc_q);
	assign limit_x = CW'(limit_q);
	assign sum_x   = pc_x + CW'(cnt_sel);
	assign diff_x  = limit_x - pc_x;
	assign fits    = sum_x <= limit_x;
	assign below   = pc_x < limit_x;

	always_comb begin
		run_load = '0;
		if (cp_pend_q) begin
			if (cp_finish) begin
				if (fits) begin
					run_load = cnt_sel;
				end else if (below) begin
					run_load = RUN_W'(diff_x[2:0]);
				end
			end
		end else if (!is_hdr && fits) begin
			run_load = cnt_sel;
		end
	end

	always_comb begin
		fill_load = '0;
		if (cp_pend_q) begin
			case (cp_nn_q) inside
				2'd0:       nib_load = {cp_hl_q, byte_q, 12'h000};
				2'd1, 2'd2: nib_load = {cp_hl_q, cp_data_q[7:0], byte_q, 4'h0};
				default:    nib_load = {cp_hl_q, cp_data_q, byte_q[7:4]};
			endcase
		end else if (is_white) begin
			nib_load  = {NIB_SLOTS{white_q}};
			fill_load = white_q;
		end else begin
			nib_load  = {NIB_SLOTS{byte_q[3:0]}};
			fill_load = byte_q[3:0];
		end
	end

	assign n0        = nib_q[NIB_REG_W-1 -: NIB_W];
	assign n1        = nib_q[NIB_REG_W-NIB_W-1 -: NIB_W];
	assign odd       = pc_q[0];
	assign pair      = ~odd && (run_q[RUN_W-1:1] != '0);
	assign step_emit = odd || pair;
	assign run_next  = odd ? (run_q - 7'd1) : (pair ? (run_q - 7'd2) : '0);
	assign pc_step   = pc_q + (pair ? PIXEL_COUNT_BITS'(2) : PIXEL_COUNT_BITS'(1));
	assign step_byte = odd ? {partial_q, n0} : {n0, n1};
	assign step_final = (run_next == '0) || ((run_next == 7'd1) && !last_q);

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= in_byte;
			last_q <= last_byte;
		end
		if (cmd.decode) begin
			nib_q  <= nib_load;
			fill_q <= fill_load;
			if (!cp_pend_q && is_hdr) begin
				cp_nn_q   <= byte_q[5:4];
				cp_hl_q   <= byte_q[3:0];
				cp_data_q <= '0;
			end else if (cp_pend_q && !cp_finish) begin
				cp_data_q <= {cp_data_q[7:0], byte_q};
			end
		end else if (cmd.step) begin
			nib_q <= pair ? {nib_q[NIB_REG_W-2*NIB_W-1:0], fill_q, fill_q}
				: {nib_q[NIB_REG_W-NIB_W-1:0], fill_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= '0;
			partial_q <= '0;
			cp_pend_q <= 1'b0;
			cp_left_q <= '0;
			run_q     <= '0;
		end else begin
			if (cmd.decode) begin
				run_q <= run_load;
				if (cp_pend_q) begin
					cp_left_q <= cp_left_dec;
					if (cp_finish) begin
						cp_pend_q <= 1'b0;
					end
				end else if (is_hdr) begin
					cp_pend_q <= 1'b1;
					cp_left_q <= copy_bytes(byte_q[5:4]);
				end
				if (last_q) begin
					cp_pend_q <= 1'b0;
					cp_left_q <= '0;
				end
			end
			if (cmd.step) begin
				pc_q  <= pc_step;
				run_q <= run_next;
				if (!step_emit) begin
					partial_q <= n0;
				end
			end
			if (cmd.flush) begin
				pc_q      <= '0;
				partial_q <= '0;
			end
		end
	end

	assign emit_any = (cmd.step && step_emit) || (cmd.flush && odd);
	assign emit_ok  = emit_any && !cap_fail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_ok) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ok) begin
			out_byte_q   <= cmd.flush ? {partial_q, 4'h0} : step_byte;
			byte_index_q <= pc_x[IDX_W:1];
			run_last_q   <= cmd.flush ? 1'b1 : step_final;
			frame_done_q <= cmd.flush ? 1'b1 : (step_final && last_q);
		end
	end

	assign stat.run_start = run_load != '0;
	assign stat.run_end   = run_next == '0;
	assign stat.last      = last_q;
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_index = byte_index_q;
	assign run_last   = run_last_q;
	assign frame_done = frame_done_q;

endmodule

>>> rtl/rle_4bpp_pixel_decoder_core.sv
// ----------------------------------------------------------------------------
// rle_4bpp_pixel_decoder_core
// run-length decoder for 4-bit-per-pixel images, one code byte per beat in,
// one packed pixel byte with its buffer index per beat out
//
// code channel: in_byte and last_byte; last_byte closes the frame, an odd
// trailing pixel is then sent with a zero low nibble
// pixels channel: out_byte, byte_index, run_last on the final beat of a code
// byte, frame_done on the final beat of the frame
// config: cfg_we, cfg_index, cfg_data; write only while the block is idle
// timing: a code byte is taken in the idle state and decoded in the next
// cycle; its beats then pass the run state and the output register, one beat
// per cycle while the output is not stalled (a white run of 64 pixels gives
// 32 beats); the last byte of a frame ends with a flush state
// the pixel stepper, which packs two pixels a cycle, sets this rate
// reset: config registers return to their defaults (white color 15), frame empty
// stall: a beat waits in the output register; the stepper pauses while it
// is held, and the next code byte is still taken once the stepper is done
// ----------------------------------------------------------------------------
module rle_4bpp_pixel_decoder_core #(
	parameter int PIXEL_COUNT_BITS = rle4_pkg::PIXEL_COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	rle4_code_if.sink                       code,
	rle4_pix_if.source                      pixels,
	input  logic                            cfg_we,
	input  rle4_pkg::cfg_reg_t              cfg_index,
	input  logic [rle4_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rle4_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     rdy;

	rle4_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (code.valid),
		.in_ready (rdy),
		.stat     (stat),
		.cmd      (cmd)
	);

	rle4_dp #(
		.PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.load       (rdy && code.valid),
		.in_byte    (code.in_byte),
		.last_byte  (code.last_byte),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (pixels.valid),
		.out_ready  (pixels.ready),
		.out_byte   (pixels.out_byte),
		.byte_index (pixels.byte_index),
		.run_last   (pixels.run_last),
		.frame_done (pixels.frame_done)
	);

	assign code.ready = rdy;

endmodule

>>> rtl/rle4_checker.sv
// ----------------------------------------------------------------------------
// rle4_checker
// port-level checks of the run-length decoder, bound to the top level
// ----------------------------------------------------------------------------
module rle4_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic [18:0] byte_index,
	input logic        run_last,
	input logic        frame_done
);

	// a held beat keeps its byte and its index
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_index))
		else $error("pixel beat changed while stalled");

	// end of frame is always the end of a code byte's beats
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> run_last)
		else $error("frame_done without run_last");

	// one code byte at a time: decode cycle follows every accepted beat
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("code byte taken during decode");

	// no pixel beat appears in the decode cycle
	a_no_early_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("pixel beat before decode");

endmodule

bind rle_4bpp_pixel_decoder_core rle4_checker u_rle4_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (code.valid),
	.in_ready   (code.ready),
	.out_valid  (pixels.valid),
	.out_ready  (pixels.ready),
	.out_byte   (pixels.out_byte),
	.byte_index (pixels.byte_index),
	.run_last   (pixels.run_last),
	.frame_done (pixels.frame_done)
);

>>> verif/rle_4bpp_pixel_decoder_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_4bpp_pixel_decoder_core_tb
// self-checking bench for the 4bpp run-length pixel decoder: code bytes go in
// with random gaps, a local decoder model predicts every packed pixel beat,
// and each beat taken from the pixel channel under random stalls is compared
// field by field; directed frames cover every code kind, frame-end cuts,
// flushes, drops and register extremes before randomized streams and a long
// output hold-off
// ----------------------------------------------------------------------------
module rle_4bpp_pixel_decoder_core_tb;
	import rle4_pkg::*;

	localparam int CYCLE_LIMIT = 1_500_000;

	typedef struct {
		logic [7:0]  out_byte;
		logic [18:0] byte_index;
		logic        run_last;
		logic        frame_done;
	} pix_beat_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_reg_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rle4_code_if code_ch();
	rle4_pix_if  pix_ch();

	rle_4bpp_pixel_decoder_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.code      (code_ch),
		.pixels    (pix_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// decoder model state and registers
	logic [19:0] pix_cnt;
	logic [7:0]  half_byte;
	logic [7:0]  copy_hdr;
	logic [23:0] copy_buf;
	logic [1:0]  copy_left;
	logic [9:0]  area_w;
	logic [9:0]  area_h;
	logic [21:0] buf_cap;
	logic [3:0]  white_nib;

	pix_beat_t step_beats[$];
	pix_beat_t expected_beats[$];
	pix_beat_t head_beat;

	int errors;
	int cycles;
	int src_mode;
	int sink_mode;
	int long_hold;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[rle_4bpp_pixel_decoder_core] ERROR");
			$finish;
		end
	end

	function automatic int draw_gap(input int mode);
		case (mode)
			0: return 0;
			1: return int'($urandom_range(0, 18));
			default: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 18)) : 0;
		endcase
	endfunction

	function automatic int unsigned area_pixels();
		return int'(area_w) * int'(area_h);
	endfunction

	function automatic void emit_byte(input logic [7:0] value);
		pix_beat_t b;
		b.out_byte   = value;
		b.byte_index = pix_cnt[19:1];
		b.run_last   = 1'b0;
		b.frame_done = 1'b0;
		step_beats.push_back(b);
	endfunction

	function automatic void put_nibble(input logic [3:0] color);
		if (pix_cnt[0]) begin
			emit_byte(half_byte | {4'h0, color});
			half_byte = 8'h00;
		end else begin
			half_byte = {color, 4'h0};
		end
		pix_cnt = pix_cnt + 20'd1;
	endfunction

	function automatic void fill_pixels(input logic [3:0] color, input int unsigned count);
		if (int'(pix_cnt) + count > area_pixels())
			return;
		for (int i = 0; i < count; i++)
			put_nibble(color);
	endfunction

	function automatic void drain_copy();
		int unsigned count;
		int unsigned k;
		int unsigned j;
		logic [7:0] b;
		logic [3:0] nib;
		count = int'(copy_hdr[5:4]) + 3;
		k = count / 2;
		for (int i = 0; i < count; i++) begin
			if (i == 0) begin
				nib = copy_hdr[3:0];
			end else begin
				j = (i - 1) / 2;
				b = 8'(copy_buf >> (8 * (k - 1 - j)));
				nib = (i % 2 == 1) ? b[7:4] : b[3:0];
			end
			if (int'(pix_cnt) + 1 <= area_pixels())
				put_nibble(nib);
		end
		copy_hdr  = 8'h00;
		copy_buf  = 24'h0;
		copy_left = 2'd0;
	endfunction

	// decode one code byte and queue the beats it produces
	function automatic void decode_code(input logic [7:0] b, input logic last);
		step_beats.delete();
		if (copy_hdr != 8'h00) begin
			copy_buf  = {copy_buf[15:0], b};
			copy_left = copy_left - 2'd1;
			if (copy_left == 2'd0)
				drain_copy();
		end else if (b[7]) begin
			if (b[6]) begin
				fill_pixels(white_nib, int'(b[5:0]) + 1);
			end else begin
				copy_hdr  = b;
				copy_buf  = 24'h0;
				copy_left = 2'((int'(b[5:4]) + 3) / 2);
			end
		end else begin
			fill_pixels(b[3:0], int'(b[6:4]) + 1);
		end
		if (last) begin
			if (pix_cnt[0])
				emit_byte(half_byte);
			pix_cnt   = 20'd0;
			half_byte = 8'h00;
			copy_hdr  = 8'h00;
			copy_buf  = 24'h0;
			copy_left = 2'd0;
		end
		if (2 * area_pixels() > int'(buf_cap))
			return;
		if (step_beats.size() > 0) begin
			step_beats[step_beats.size() - 1].run_last   = 1'b1;
			step_beats[step_beats.size() - 1].frame_done = last;
		end
		foreach (step_beats[i])
			expected_beats.push_back(step_beats[i]);
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [21:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_AREA_WIDTH:  area_w    = value[9:0];
			REG_AREA_HEIGHT: area_h    = value[9:0];
			REG_OUT_CAP:     buf_cap   = value;
			REG_WHITE_COLOR: white_nib = value[3:0];
			default: ;
		endcase
	endtask

	task automatic set_area(input int w, input int h, input int cap, input int white);
		write_reg(REG_AREA_WIDTH, {12'($urandom_range(0, 4095)), 10'(w)});
		write_reg(REG_AREA_HEIGHT, {12'($urandom_range(0, 4095)), 10'(h)});
		write_reg(REG_OUT_CAP, 22'(cap));
		write_reg(REG_WHITE_COLOR, {18'($urandom_range(0, 262143)), 4'(white)});
	endtask

	task automatic send_code(input logic [7:0] b, input logic last);
		int gap;
		gap = draw_gap(src_mode);
		if (gap > 0) begin
			code_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		code_ch.valid     <= 1'b1;
		code_ch.in_byte   <= b;
		code_ch.last_byte <= last;
		do @(posedge clk); while (!code_ch.ready);
		decode_code(b, last);
	endtask

	// stop sending and let every expected beat come out
	task automatic wait_drain();
		code_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_beats.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_idling();
		src_mode  = $urandom_range(0, 2);
		sink_mode = $urandom_range(0, 2);
	endtask

	task automatic send_random_stream(input int n_items, input int last_odds,
			input bit may_pause);
		int sent;
		int kind;
		int ncont;
		int cutpos;
		bit cut_done;
		logic [7:0] hdr;
		logic [7:0] b;
		logic last;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(0, 99);
			if (kind >= 55 && kind < 85) begin
				hdr = {2'b10, 6'($urandom_range(0, 63))};
				ncont = (int'(hdr[5:4]) + 3) / 2;
				cutpos = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, ncont - 1)) : -1;
				cut_done = 1'b0;
				for (int i = 0; i <= ncont && !cut_done; i++) begin
					b = (i == 0) ? hdr : 8'($urandom_range(0, 255));
					if (i == cutpos) begin
						last = 1'b1;
						cut_done = 1'b1;
					end else begin
						last = (i == ncont) && ($urandom_range(1, last_odds) == 1);
					end
					send_code(b, last);
					sent++;
				end
			end else begin
				if (kind < 30)
					b = {1'b0, 7'($urandom_range(0, 127))};
				else if (kind < 55)
					b = {2'b11, 6'($urandom_range(0, 63))};
				else
					b = 8'($urandom_range(0, 255));
				last = ($urandom_range(1, last_odds) == 1);
				send_code(b, last);
				sent++;
			end
			if (may_pause && $urandom_range(0, 59) == 0)
				wait_drain();
		end
	endtask

	task automatic test_basic_ops();
		src_mode  = 1;
		sink_mode = 1;
		set_area(16, 4, 128, 15);
		send_code(8'h00, 1'b0);
		send_code(8'h7F, 1'b0);
		send_code(8'hC0, 1'b0);
		send_code(8'h80, 1'b0);
		send_code(8'h5A, 1'b0);
		send_code(8'hBF, 1'b0);
		send_code(8'h12, 1'b0);
		send_code(8'h34, 1'b0);
		send_code(8'h56, 1'b0);
		send_code(8'h95, 1'b0);
		send_code(8'hAB, 1'b0);
		send_code(8'hA3, 1'b0);
		send_code(8'hEF, 1'b0);
		send_code(8'h01, 1'b0);
		send_code(8'hFF, 1'b0);
		send_code(8'h20, 1'b0);
		send_code(8'hB0, 1'b0);
		send_code(8'h12, 1'b1);
		wait_drain();
	endtask

	task automatic test_frame_edges();
		src_mode  = 2;
		sink_mode = 2;
		// copy partly past the frame end, then a run that no longer fits
		set_area(2, 2, 8, 15);
		send_code(8'h20, 1'b0);
		send_code(8'hB5, 1'b0);
		send_code(8'h12, 1'b0);
		send_code(8'h34, 1'b0);
		send_code(8'h56, 1'b0);
		send_code(8'h00, 1'b1);
		wait_drain();
		// buffer too small, state still advances
		write_reg(REG_OUT_CAP, 22'd7);
		send_code(8'h30, 1'b1);
		send_code(8'h20, 1'b0);
		wait_drain();
		write_reg(REG_OUT_CAP, 22'd8);
		send_code(8'h00, 1'b1);
		wait_drain();
	endtask

	task automatic test_config_extremes();
		src_mode  = 0;
		sink_mode = 0;
		set_area(0, 1023, 0, 15);
		send_code(8'h7F, 1'b1);
		wait_drain();
		set_area(5, 0, 0, 15);
		send_code(8'hC3, 1'b1);
		wait_drain();
		set_area(1023, 1023, 2097152, 0);
		send_code(8'hC3, 1'b0);
		send_code(8'hFF, 1'b0);
		send_code(8'hC0, 1'b1);
		wait_drain();
		set_area(1023, 1023, 22'h3FFFFF, 15);
		send_code(8'hC1, 1'b1);
		wait_drain();
	endtask

	task automatic test_random_streams();
		int w;
		int h;
		set_idling();
		set_area(1023, 1023, 2097152, $urandom_range(0, 15));
		send_random_stream(110, 20, 1'b1);
		wait_drain();
		set_idling();
		w = $urandom_range(1, 24);
		h = $urandom_range(1, 8);
		set_area(w, h, 2 * w * h + int'($urandom_range(0, 5)), $urandom_range(0, 15));
		send_random_stream(110, 8, 1'b1);
		wait_drain();
		set_idling();
		set_area(1, 1, 2, $urandom_range(0, 15));
		send_random_stream(30, 3, 1'b1);
		wait_drain();
		set_idling();
		set_area(5, 3, 29, $urandom_range(0, 15));
		send_random_stream(25, 6, 1'b1);
		wait_drain();
		set_idling();
		set_area($urandom_range(1, 1023), 1, 22'h3FFFFF, $urandom_range(0, 15));
		send_random_stream(40, 10, 1'b1);
		wait_drain();
		set_idling();
		set_area(1, 1023, 2046, $urandom_range(0, 15));
		send_random_stream(25, 10, 1'b1);
		wait_drain();
	endtask

	task automatic test_backpressure();
		set_area(1023, 1023, 2097152, $urandom_range(0, 15));
		src_mode  = 0;
		sink_mode = 2;
		long_hold = 400;
		send_random_stream(40, 40, 1'b0);
		wait_drain();
	endtask

	// pixel channel sink with random stalls and long hold-offs
	initial begin
		int stall;
		pix_ch.ready <= 1'b0;
		forever begin
			if (long_hold > 0) begin
				pix_ch.ready <= 1'b0;
				repeat (long_hold) @(posedge clk);
				long_hold = 0;
			end
			stall = draw_gap(sink_mode);
			if (stall > 0) begin
				pix_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pix_ch.ready <= 1'b1;
			do @(posedge clk); while (!pix_ch.valid && long_hold == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			if (expected_beats.size() == 0) begin
				$error("unexpected beat: out_byte %0h byte_index %0h", pix_ch.out_byte,
					pix_ch.byte_index);
				errors++;
			end else begin
				head_beat = expected_beats.pop_front();
				if (pix_ch.out_byte !== head_beat.out_byte) begin
					$error("out_byte: expected %0h, got %0h", head_beat.out_byte,
						pix_ch.out_byte);
					errors++;
				end
				if (pix_ch.byte_index !== head_beat.byte_index) begin
					$error("byte_index: expected %0h, got %0h", head_beat.byte_index,
						pix_ch.byte_index);
					errors++;
				end
				if (pix_ch.run_last !== head_beat.run_last) begin
					$error("run_last: expected %0b, got %0b", head_beat.run_last,
						pix_ch.run_last);
					errors++;
				end
				if (pix_ch.frame_done !== head_beat.frame_done) begin
					$error("frame_done: expected %0b, got %0b", head_beat.frame_done,
						pix_ch.frame_done);
					errors++;
				end
			end
		end
	end

	initial begin
		errors    = 0;
		cycles    = 0;
		src_mode  = 0;
		sink_mode = 0;
		long_hold = 0;
		pix_cnt   = 20'd0;
		half_byte = 8'h00;
		copy_hdr  = 8'h00;
		copy_buf  = 24'h0;
		copy_left = 2'd0;
		area_w    = 10'd0;
		area_h    = 10'd0;
		buf_cap   = 22'd0;
		white_nib = WHITE_RESET;
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= REG_AREA_WIDTH;
		cfg_data          <= '0;
		code_ch.valid     <= 1'b0;
		code_ch.in_byte   <= 8'h00;
		code_ch.last_byte <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_frame_edges();
		test_config_extremes();
		test_random_streams();
		test_backpressure();

		wait_drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_beats.size() == 0) begin
			$display("[rle_4bpp_pixel_decoder_core] OK");
		end else begin
			$display("[rle_4bpp_pixel_decoder_core] ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/rle4_pkg.sv
rtl/rle4_code_if.sv
rtl/rle4_pix_if.sv
rtl/rle4_ctrl.sv
rtl/rle4_dp.sv
rtl/rle_4bpp_pixel_decoder_core.sv
rtl/rle4_checker.sv
verif/rle_4bpp_pixel_decoder_core_tb.sv
